/* design/mi_pkg.sv */
package mi_pkg;

  // operand width of value, modulus and result
  localparam int WIDTH = 32;
  // bit counter width of the iterative divider
  localparam int CNT_W = $clog2(WIDTH);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch a new item
    logic div_init;    // start value mod modulus
    logic take_init;   // keep the first remainder
    logic div_step;    // start r_old / r_cur
    logic mul;         // quotient times newer coefficient
    logic upd;         // advance remainder and coefficient pairs
    logic fin_calc;    // fold the sign into the coefficient
    logic emit;        // load the output register
    logic emit_found;  // the result is a real inverse
  } mi_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mod_small;   // modulus below two
    logic r_zero;      // newer remainder is zero
    logic r_one;       // newer remainder is one
    logic div_done;    // divider finished this cycle
    logic out_free;    // output register can take a result
  } mi_stat_t;

endpackage

/* design/mi_div.sv */
module mi_div import mi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* design/mi_dp.sv */
module mi_dp import mi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mi_cmd_t          cmd_i,
  output mi_stat_t         stat_o,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);

  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] r_old_q, r_cur_q;
  logic [WIDTH-1:0] c_old_q, c_cur_q;
  logic             neg_q;
  logic [WIDTH-1:0] prod_q;
  logic [WIDTH-1:0] fin_q;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] inverse_q;
  logic             no_inverse_q;
  logic             div_start;
  logic [WIDTH-1:0] div_n, div_d;
  logic             div_done;
  logic [WIDTH-1:0] div_quo, div_rem;

  // shared divider: first value mod modulus, then r_old / r_cur
  assign div_start = cmd_i.div_init | cmd_i.div_step;
  assign div_n     = cmd_i.div_init ? r_cur_q : r_old_q;
  assign div_d     = cmd_i.div_init ? r_old_q : r_cur_q;

  mi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // remainder and coefficient pairs
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mod_q   <= modulus_i;
      r_old_q <= modulus_i;
      r_cur_q <= value_i;
      c_old_q <= '0;
      c_cur_q <= WIDTH'(1);
      neg_q   <= 1'b0;
    end else if (cmd_i.take_init) begin
      r_cur_q <= div_rem;
    end else if (cmd_i.upd) begin
      r_old_q <= r_cur_q;
      r_cur_q <= div_rem;
      c_old_q <= c_cur_q;
      c_cur_q <= c_old_q + prod_q;
      neg_q   <= ~neg_q;
    end
    // magnitudes stay at or below the modulus, so the low half suffices
    if (cmd_i.mul) begin
      prod_q <= div_quo * c_cur_q;
    end
    if (cmd_i.fin_calc) begin
      fin_q <= neg_q ? (mod_q - c_cur_q) : c_cur_q;
    end
  end

  // output register, set on emit and cleared by an output transfer
  assign out_valid_d = cmd_i.emit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.emit_found) begin
        inverse_q <= (fin_q >= mod_q) ? (fin_q - mod_q) : fin_q;
      end else begin
        inverse_q <= '0;
      end
      no_inverse_q <= ~cmd_i.emit_found;
    end
  end

  // status
  assign stat_o.mod_small = (mod_q < WIDTH'(2));
  assign stat_o.r_zero    = (r_cur_q == '0);
  assign stat_o.r_one     = (r_cur_q == WIDTH'(1));
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = ~out_valid_q | ~out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign inverse_o    = inverse_q;
  assign no_inverse_o = no_inverse_q;

endmodule

/* design/mi_ctrl.sv */
module mi_ctrl import mi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mi_stat_t stat_i,
  output mi_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_TEST = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       found_q, found_d;

  // sequencing of one item
  always_comb begin
    state_d = state_q;
    found_d = found_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.mod_small) begin
          found_d = 1'b0;
          state_d = S_FIN;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_INIT;
        end
      end
      S_INIT: begin
        if (stat_i.div_done) begin
          cmd_o.take_init = 1'b1;
          state_d         = S_TEST;
        end
      end
      S_TEST: begin
        if (stat_i.r_zero) begin
          found_d = 1'b0;
          state_d = S_FIN;
        end else if (stat_i.r_one) begin
          cmd_o.fin_calc = 1'b1;
          found_d        = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.mul = 1'b1;
          state_d   = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_TEST;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_found = found_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

endmodule

/* design/modular_inverse.sv */
// Modular inverse by the extended Euclidean algorithm.
// Input channel: in_valid_i / in_stall_o with value_i and modulus_i; a transfer
// happens on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with inverse_o and no_inverse_o.
// inverse_o is the inverse of value_i modulo modulus_i in 0..modulus-1;
// no_inverse_o is set, with inverse_o zero, when the gcd exceeds one, the
// value reduces to zero, or the modulus is below two.
// One item is worked on at a time. Each division runs on a shared
// one-bit-per-cycle divider, and one Euclid step is a test, a division
// and an update. The next input transfer can follow once the result is
// loaded into the output register; at WIDTH 32 the longest chain
// (consecutive Fibonacci operands) runs 44 steps, and 1.44*WIDTH steps
// would bound it. A modulus below two goes to its result without a
// division; any other item pays the initial reduction, even a value that
// reduces to zero or one.
// The result sits in an output register, so a new item is taken as soon as
// the previous one is handed to it, even while the receiver stalls; a held
// result keeps its value until it is transferred.
// Reset clears the controller and the output valid; no item is in flight.
module modular_inverse import mi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);

  mi_cmd_t  cmd;
  mi_stat_t stat;

  // controller
  mi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  mi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (value_i),
    .modulus_i    (modulus_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .inverse_o    (inverse_o),
    .no_inverse_o (no_inverse_o)
  );

`ifndef ASSERT_OFF
  // an accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // a flagged result carries a zero inverse
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_inverse_o |-> inverse_o == '0)
    else $error("flagged result with nonzero inverse");

  // a real inverse is never zero
  a_inverse_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !no_inverse_o |-> inverse_o != '0)
    else $error("zero inverse without flag");
`endif

endmodule
